// ----- design/min_max_jump_search_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef MIN_MAX_JUMP_SEARCH_TOP_ASSERT_SVH
`define MIN_MAX_JUMP_SEARCH_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MMJ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define MMJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/mmjs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmjs_pkg
// Types and constants shared by the jump search block.
// ----------------------------------------------------------------------------
package mmjs_pkg;
  localparam int unsigned POS_W = 32;
  localparam int unsigned JUMP_W = 11;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             has_stone;
    logic             last_item;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] min_jump;
    logic             feasible;
  } out_word_t;

  localparam logic CFG_RIVER_LENGTH = 1'b0;
  localparam logic CFG_MAX_JUMPS    = 1'b1;

  // Control between the sequencer and the stone store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;
endpackage

// ----- design/min_max_jump_search_top.sv -----
// ----------------------------------------------------------------------------
// min_max_jump_search_top
// Stores a set of stones in order and binary-searches the smallest jump length.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        input      in_valid / in_ready / in_data   (one stone word)
// out       output     out_valid / out_ready / out_data (one result word per set)
// cfg       input      cfg_valid / cfg_ready / cfg_index / cfg_data
//
// A word that carries a stone is stored by an insertion pass through the single
// memory port: each stone already held above the new one is read and moved up
// one place, then the new stone is written. A word without a stone is only
// accepted. A last word starts the search: about log2(river_length) probes,
// each a probe set-up, a greedy scan that reads every landing point and fetches
// the previous point for each jump, an end test and a verdict, all through one
// shared add-and-compare unit. Reset (synchronous, rst) empties the set. The
// result register holds its word until taken; input stays stalled meanwhile.
module min_max_jump_search_top #(
  parameter int unsigned MAX_STONES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mmjs_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mmjs_pkg::out_word_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);
  import mmjs_pkg::*;

  localparam int unsigned AW = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;
  localparam int unsigned CW = $clog2(MAX_STONES + 2);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_INS_RD = 10'b0000000010, // read the stone below the insertion point
    S_INS_CK = 10'b0000000100, // compare it against the new stone
    S_MID    = 10'b0000001000, // form the next probe length
    S_SC_RD  = 10'b0000010000, // fetch landing point scan_index
    S_SC_CK  = 10'b0000100000, // reach test with the shared adder
    S_PREV   = 10'b0001000000, // fetch previous point before a jump
    S_PREV_CK= 10'b0010000000, // land on it
    S_VERD   = 10'b0100000000, // probe verdict
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]  river_length;
  logic [JUMP_W-1:0] max_jumps;
  logic [CW-1:0]     stone_count;
  logic [POS_W:0]    search_low, search_high, probe;
  logic [POS_W-1:0]  best_length;
  logic              found;
  logic [CW-1:0]     scan_index, ins_k;
  logic [POS_W-1:0]  last_landing, new_stone;
  logic [CW-1:0]     jump_count;
  logic              last_pending;
  logic              pt_from_mem;
  logic [POS_W-1:0]  pt_const;

  mem_ctrl_t         mctl;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [POS_W-1:0]  wr_data, rd_data;

  mmjs_store #(.DEPTH(MAX_STONES), .AW(AW)) u_store (
    .clk(clk), .ctrl(mctl), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Current landing point: start, a stored stone or the far end.
  logic [POS_W-1:0] point;
  assign point = pt_from_mem ? rd_data : pt_const;

  // The shared unit: one wide add and compare.
  logic [POS_W:0] sum;
  logic           reach;
  assign sum   = {1'b0, last_landing} + probe;
  assign reach = sum >= {1'b0, point};

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{min_jump: best_length, feasible: found};

  logic [POS_W-1:0] clamped;
  assign clamped = (in_data.position > river_length) ? river_length : in_data.position;

  logic [CW-1:0] limit;
  assign limit = stone_count + CW'(1);

  always_comb begin
    mctl    = '0;
    rd_addr = '0;
    wr_addr = ins_k[AW-1:0];
    wr_data = new_stone;
    if (state == S_INS_RD) begin
      mctl.rd_en = 1'b1;
      rd_addr    = AW'(ins_k - CW'(1));
    end
    if (state == S_SC_RD) begin
      mctl.rd_en = 1'b1;
      rd_addr    = AW'(scan_index - CW'(1));
    end
    // The previous-point read addresses stone scan_index-1, i.e. memory scan_index-2.
    if (state == S_PREV) begin
      mctl.rd_en = 1'b1;
      rd_addr    = AW'(scan_index - CW'(2));
    end
    if (state == S_INS_CK && (ins_k == '0 || rd_data <= new_stone)) begin
      mctl.wr_en = 1'b1;
    end
    if (state == S_INS_CK && ins_k != '0 && rd_data > new_stone) begin
      mctl.wr_en = 1'b1;
      wr_data    = rd_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) begin
        state_next = (in_data.has_stone && stone_count < CW'(MAX_STONES)) ? S_INS_RD :
                     (in_data.last_item ? S_MID : S_IDLE);
      end
      S_INS_RD:  state_next = (ins_k == '0) ? S_INS_CK : S_INS_CK;
      S_INS_CK:  state_next = (ins_k != '0 && rd_data > new_stone) ? S_INS_RD :
                              (last_pending ? S_MID : S_IDLE);
      S_MID:     state_next = (search_low <= search_high) ? S_SC_RD : S_OUT;
      S_SC_RD:   state_next = (scan_index > limit) ? S_VERD : S_SC_CK;
      S_SC_CK:   state_next = reach ? S_SC_RD : S_PREV;
      S_PREV:    state_next = S_PREV_CK;
      S_PREV_CK: state_next = (point == last_landing) ? S_VERD : S_SC_RD;
      S_VERD:    state_next = S_MID;
      S_OUT:     state_next = out_ready ? S_IDLE : S_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      river_length <= POS_W'(1);
      max_jumps    <= JUMP_W'(1);
      stone_count  <= '0;
      search_low   <= (POS_W+1)'(1);
      search_high  <= '0;
      best_length  <= '0;
      found        <= 1'b0;
      scan_index   <= '0;
      last_landing <= '0;
      jump_count   <= '0;
      last_pending <= 1'b0;
      ins_k        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RIVER_LENGTH: river_length <= cfg_data;
          CFG_MAX_JUMPS:    max_jumps <= cfg_data[JUMP_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          new_stone    <= clamped;
          ins_k        <= stone_count;
          last_pending <= in_data.last_item;
          search_low   <= (POS_W+1)'(1);
          search_high  <= {1'b0, river_length};
          best_length  <= '0;
          found        <= 1'b0;
          if (in_data.has_stone && stone_count < CW'(MAX_STONES)) begin
            stone_count <= stone_count + CW'(1);
          end
        end
        S_INS_CK: if (ins_k != '0 && rd_data > new_stone) begin
          ins_k <= ins_k - CW'(1);
        end
        S_MID: begin
          probe        <= (search_low + search_high) >> 1;
          scan_index   <= CW'(1);
          last_landing <= '0;
          jump_count   <= '0;
        end
        S_SC_RD: begin
          pt_from_mem <= (scan_index <= stone_count);
          pt_const    <= river_length;
        end
        S_SC_CK: begin
          if (reach) begin
            scan_index <= scan_index + CW'(1);
          end
        end
        S_PREV: begin
          pt_from_mem <= (scan_index > CW'(1));
          pt_const    <= '0;
        end
        S_PREV_CK: if (point != last_landing) begin
          last_landing <= point;
          jump_count   <= jump_count + CW'(1);
        end
        S_VERD: begin
          if (scan_index > limit &&
              ({1'b0, jump_count} + (CW+1)'(1)) <= (CW+1)'(max_jumps)) begin
            best_length <= probe[POS_W-1:0];
            found       <= 1'b1;
            search_high <= probe - (POS_W+1)'(1);
          end else begin
            search_low  <= probe + (POS_W+1)'(1);
          end
        end
        S_OUT: if (out_ready) begin
          stone_count <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- design/mmjs_store.sv -----
// ----------------------------------------------------------------------------
// mmjs_store
// Single-port-write, single-read stone memory with registered read data.
// ----------------------------------------------------------------------------
module mmjs_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk,
  input  mmjs_pkg::mem_ctrl_t       ctrl,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mmjs_pkg::POS_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [mmjs_pkg::POS_W-1:0] rd_data
);
  import mmjs_pkg::*;
  logic [POS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- design/mmjs_checker.sv -----
// ----------------------------------------------------------------------------
// mmjs_checker
// Port-level checks on the jump search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_max_jump_search_top_assert.svh"
module mmjs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                cfg_ready,
  input mmjs_pkg::out_word_t out_data
);
  // Input is never taken while a result is shown.
  `MMJ_ASSERT_IMPL(a_no_in_with_out, out_valid, !in_ready)
  // Configuration is accepted only when input would be.
  `MMJ_ASSERT_IMPL(a_cfg_idle, cfg_ready, in_ready)
  // An infeasible result carries a zero length.
  `MMJ_ASSERT_IMPL(a_zero_when_none, out_valid && !out_data.feasible, out_data.min_jump == '0)
  // A shown result stays until taken.
  `MMJ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind min_max_jump_search_top mmjs_checker u_mmjs_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
  .out_data(out_data)
);

// ----- tb/min_max_jump_search_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_jump_search_top_tb
// Self-checking bench for the smallest largest-jump search block.
// Stone words are sent over the input channel and each set ends with a last
// word. A behavioural predictor sorts the stones and binary-searches the
// smallest feasible jump, and every result word is compared against it.
// ----------------------------------------------------------------------------
module min_max_jump_search_top_tb;
  import mmjs_pkg::*;

  localparam int unsigned N_STONES = 1024;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_RIVER_LENGTH;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  min_max_jump_search_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: the configuration as the block should hold it, and the
  // sorted stones of the set in progress.
  logic [31:0] pred_length = 32'd1;
  logic [10:0] pred_jumps  = 11'd1;
  logic [31:0] sorted_stones[$];
  out_word_t   expected_words[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;

  // Idling percentages and the long hold-off request for the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;

  // Greedy scan: can the far end be reached with jumps no longer than len?
  // Landing points are 0, the stones in order, then the far end.
  function automatic bit reaches_end(logic [32:0] len);
    logic [32:0] landing;
    logic [32:0] here;
    logic [32:0] prev;
    int unsigned hops;
    int unsigned k;
    landing = '0;
    hops = 0;
    k = 1;
    while (k <= sorted_stones.size() + 1) begin
      here = (k <= sorted_stones.size()) ? {1'b0, sorted_stones[k-1]} : {1'b0, pred_length};
      if (landing + len >= here) begin
        k++;
      end else begin
        prev = (k == 1) ? 33'd0 : {1'b0, sorted_stones[k-2]};
        if (prev == landing) return 1'b0;
        landing = prev;
        hops++;
      end
    end
    hops++;
    return hops <= pred_jumps;
  endfunction

  // Applies one accepted word to the predictor and queues any result.
  task automatic predict_word(in_word_t w);
    logic [31:0] pos;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] mid;
    int unsigned k;
    out_word_t r;
    if (w.has_stone && sorted_stones.size() < N_STONES) begin
      pos = (w.position > pred_length) ? pred_length : w.position;
      k = 0;
      while (k < sorted_stones.size() && sorted_stones[k] <= pos) k++;
      sorted_stones.insert(k, pos);
    end
    if (w.last_item) begin
      lo = 33'd1;
      hi = {1'b0, pred_length};
      r = '0;
      while (lo <= hi) begin
        mid = (lo + hi) >> 1;
        if (reaches_end(mid)) begin
          r.min_jump = mid[31:0];
          r.feasible = 1'b1;
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      expected_words.push_back(r);
      sorted_stones.delete();
    end
  endtask

  // Offers one word, holding it steady until the block takes it.
  task automatic send_word(logic [31:0] pos, bit has, bit last);
    in_word_t w;
    w.position = pos;
    w.has_stone = has;
    w.last_item = last;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_word(w);
    words_sent++;
    in_valid <= 1'b0;
  endtask

  // Waits for every expected result, then lets the block settle before a
  // register write. Stone words cause no result, so a spare pause covers an
  // insertion pass that may still be running.
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2 * N_STONES + 16) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_RIVER_LENGTH) pred_length = val;
    else pred_jumps = val[10:0];
  endtask

  task automatic set_config(logic [31:0] len, logic [10:0] jumps);
    drain();
    write_reg(CFG_RIVER_LENGTH, len);
    write_reg(CFG_MAX_JUMPS, {21'd0, jumps});
  endtask

  // Sends a set of n random stones, ending with a last word.
  task automatic send_set(int unsigned n, logic [31:0] span);
    for (int unsigned i = 0; i < n; i++)
      send_word($urandom_range(span, 0), 1'b1, i == n - 1);
    if (n == 0) send_word($urandom, 1'b0, 1'b1);
  endtask

  // Directed cases: reset values, extremes, no jumps, zero length, clamping,
  // an empty set, a last word without a stone and a stuck scan.
  task automatic test_directed();
    send_word(32'd0, 1'b0, 1'b1);
    set_config(32'd100, 11'd3);
    send_word(32'd30, 1'b1, 1'b0);
    send_word(32'd60, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(32'd90, 1'b1, 1'b1);
    send_word(32'd50, 1'b1, 1'b0);
    send_word(32'd10, 1'b0, 1'b1);
    set_config(32'd100, 11'd0);
    send_word(32'd50, 1'b1, 1'b1);
    set_config(32'd0, 11'd2);
    send_word(32'd5, 1'b1, 1'b1);
    set_config(32'hFFFF_FFFF, 11'd1025);
    send_word(32'h5555_5555, 1'b1, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b1, 1'b1);
    set_config(32'hFFFF_FFFF, 11'd2047);
    send_word(32'h8000_0000, 1'b1, 1'b1);
    set_config(32'd1000, 11'd1);
    send_word(32'd999, 1'b1, 1'b0);
    send_word(32'd1, 1'b1, 1'b1);
  endtask

  // A full store: further stones of the set are dropped.
  task automatic test_full_store();
    set_config(32'd5000, 11'd40);
    for (int unsigned i = 0; i < N_STONES + 3; i++)
      send_word($urandom_range(5000, 0), 1'b1, i == N_STONES + 2);
  endtask

  // The receiver holds off while several sets are offered.
  task automatic test_back_pressure();
    set_config(32'd200, 11'd4);
    hold_off_cycles = 3000;
    repeat (4) send_set($urandom_range(6, 1), 32'd250);
  endtask

  // Random sets, mostly small, under one idling pattern.
  task automatic test_random(int unsigned n_words, int unsigned s_pct, int unsigned r_pct);
    int unsigned target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = words_sent + n_words;
    while (words_sent < target) begin
      case ($urandom_range(3, 0))
        0: set_config($urandom_range(64, 0), 11'($urandom_range(6, 0)));
        1: set_config($urandom, 11'($urandom_range(1025, 0)));
        default: set_config($urandom_range(100000, 1), 11'($urandom_range(12, 1)));
      endcase
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9, 0) == 0) send_word($urandom, 1'b0, $urandom_range(1, 0));
        else send_set($urandom_range(12, 0),
                      ($urandom_range(3, 0) == 0) ? $urandom : pred_length + 8);
      end
    end
  endtask

  // Receiver: random readiness, plus any requested long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Checker: each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %h", out_data);
        errors++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_data.min_jump !== e.min_jump) begin
          $error("min_jump expected %0d got %0d", e.min_jump, out_data.min_jump);
          errors++;
        end
        if (out_data.feasible !== e.feasible) begin
          $error("feasible expected %0b got %0b", e.feasible, out_data.feasible);
          errors++;
        end
      end
      results_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_store();
    test_back_pressure();
    test_random(200, 8, 88);
    test_random(200, 88, 8);
    test_random(200, 0, 0);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d stone words and checked %0d results,", words_sent, results_seen);
    $display("across varied lengths, jump limits and idling patterns.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/mmjs_pkg.sv
design/mmjs_store.sv
design/min_max_jump_search_top.sv
design/mmjs_checker.sv
tb/min_max_jump_search_top_tb.sv
